[design/tgarle_pkg.sv]
// Shared types and constants for the TGA run-length pixel decoder.
// Used by every module of the decoder; depends on nothing.
package tgarle_pkg;

  localparam int unsigned PixelCountBitsDefault = 32;
  localparam int unsigned ColorBits = 32;
  localparam int unsigned RepeatBits = 8;
  localparam int unsigned BppBits = 3;
  localparam int unsigned CfgDataBits = 32;

  localparam logic [7:0] RunHeaderMin = 8'd128;
  localparam logic [7:0] RunHeaderBias = 8'd127;

  localparam logic [BppBits-1:0] BppReset = 3'd3;
  localparam logic [CfgDataBits-1:0] PixelTotalReset = 32'd1;

  typedef enum logic [0:0] {
    CFG_BYTES_PER_PIXEL = 1'b0,
    CFG_PIXEL_TOTAL     = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_START = 2'd1,
    CMD_END   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_MANY  = 2'd1,
    STAT_EARLY_END = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    EVT_PIXEL = 2'd0,
    EVT_END   = 2'd1,
    EVT_CLEAR = 2'd2
  } evt_kind_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [ColorBits-1:0]  pixel_color;
    logic [RepeatBits-1:0] repeat_count;
    logic                  end_of_image;
    status_e               status;
  } out_item_t;

  typedef struct packed {
    evt_kind_e             kind;
    logic [ColorBits-1:0]  color;
    logic [RepeatBits-1:0] rep;
    logic                  last;
  } evt_t;

endpackage

[design/tgarle_front.sv]
// Front end: takes stream items, parses packet headers and gathers pixel bytes.
// Pushes pixel, end and clear events to the queue. Depends on tgarle_pkg.
module tgarle_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  tgarle_pkg::in_item_t                 in_item_i,
  input  logic [tgarle_pkg::BppBits-1:0]       bpp_i,
  output logic                                 push_o,
  output tgarle_pkg::evt_t                     evt_o,
  input  logic                                 push_ready_i
);

  logic                                awaiting_q, awaiting_d;
  logic                                is_run_q, is_run_d;
  logic [tgarle_pkg::RepeatBits-1:0]   left_q, left_d;
  logic [1:0]                          pos_q, pos_d;
  logic [tgarle_pkg::ColorBits-1:0]    gather_q, gather_d;
  logic [tgarle_pkg::BppBits-1:0]      bpp_eff;
  logic [tgarle_pkg::ColorBits-1:0]    gather_new;
  logic                                accept;
  logic                                last_byte;

  assign in_ready_o = push_ready_i;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    case (bpp_i) inside
      3'd0: bpp_eff = 3'd1;
      [3'd1:3'd4]: bpp_eff = bpp_i;
      default: bpp_eff = 3'd4;
    endcase
  end

  assign gather_new = gather_q
                      | (tgarle_pkg::ColorBits'(in_item_i.data_byte) << {pos_q, 3'b000});
  assign last_byte = ({1'b0, pos_q} + 3'd1) >= bpp_eff;

  always_comb begin
    awaiting_d = awaiting_q;
    is_run_d   = is_run_q;
    left_d     = left_q;
    pos_d      = pos_q;
    gather_d   = gather_q;
    push_o     = 1'b0;
    evt_o.kind  = tgarle_pkg::EVT_PIXEL;
    evt_o.color = gather_new;
    evt_o.rep   = is_run_q ? left_q : 8'd1;
    evt_o.last  = is_run_q || (left_q == 8'd1);
    if (accept) begin
      case (in_item_i.command)
        tgarle_pkg::CMD_DATA: begin
          if (awaiting_q) begin
            if (in_item_i.data_byte < tgarle_pkg::RunHeaderMin) begin
              is_run_d = 1'b0;
              left_d   = in_item_i.data_byte + 8'd1;
            end else begin
              is_run_d = 1'b1;
              left_d   = in_item_i.data_byte - tgarle_pkg::RunHeaderBias;
            end
            awaiting_d = 1'b0;
            pos_d      = 2'd0;
            gather_d   = '0;
          end else if (!last_byte) begin
            gather_d = gather_new;
            pos_d    = pos_q + 2'd1;
          end else begin
            push_o     = 1'b1;
            gather_d   = '0;
            pos_d      = 2'd0;
            left_d     = is_run_q ? 8'd0 : left_q - 8'd1;
            awaiting_d = evt_o.last;
          end
        end
        tgarle_pkg::CMD_START: begin
          push_o     = 1'b1;
          evt_o.kind = tgarle_pkg::EVT_CLEAR;
          awaiting_d = 1'b1;
          is_run_d   = 1'b0;
          left_d     = '0;
          pos_d      = 2'd0;
          gather_d   = '0;
        end
        tgarle_pkg::CMD_END: begin
          push_o     = 1'b1;
          evt_o.kind = tgarle_pkg::EVT_END;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b1;
      is_run_q   <= 1'b0;
      left_q     <= '0;
      pos_q      <= 2'd0;
      gather_q   <= '0;
    end else begin
      awaiting_q <= awaiting_d;
      is_run_q   <= is_run_d;
      left_q     <= left_d;
      pos_q      <= pos_d;
      gather_q   <= gather_d;
    end
  end

endmodule

[design/tgarle_queue.sv]
// Two-entry event queue between front and back ends.
// Depends on tgarle_pkg for the event type.
module tgarle_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tgarle_pkg::evt_t push_evt_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output tgarle_pkg::evt_t pop_evt_o,
  input  logic             pop_i
);

  tgarle_pkg::evt_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_evt_o    = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_evt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[design/tgarle_back.sv]
// Back end: counts pixels against the total, flags image end and errors,
// and holds the output register. Depends on tgarle_pkg.
module tgarle_back #(
  parameter int unsigned PixelCountBits = tgarle_pkg::PixelCountBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      evt_valid_i,
  input  tgarle_pkg::evt_t          evt_i,
  output logic                      evt_pop_o,
  input  logic [PixelCountBits-1:0] total_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tgarle_pkg::out_item_t     out_item_o
);

  logic [PixelCountBits-1:0] done_q, done_d;
  logic                      finished_q, finished_d;
  logic                      failed_q, failed_d;
  logic                      out_valid_q, out_valid_d;
  tgarle_pkg::out_item_t     out_q, out_d;
  logic                      slot_free;
  logic [PixelCountBits-1:0] missing;
  logic [PixelCountBits-1:0] rep_ext;
  logic [PixelCountBits-1:0] done_sum;
  logic                      over;
  logic [tgarle_pkg::RepeatBits-1:0] rep_clip;

  assign slot_free = !out_valid_q || out_ready_i;
  assign evt_pop_o = evt_valid_i && slot_free;

  assign missing  = (done_q < total_i) ? total_i - done_q : '0;
  assign rep_ext  = PixelCountBits'(evt_i.rep);
  assign over     = rep_ext > missing;
  assign done_sum = done_q + rep_ext;
  assign rep_clip = missing[tgarle_pkg::RepeatBits-1:0];

  always_comb begin
    done_d      = done_q;
    finished_d  = finished_q;
    failed_d    = failed_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (evt_pop_o) begin
      case (evt_i.kind)
        tgarle_pkg::EVT_CLEAR: begin
          done_d     = '0;
          finished_d = 1'b0;
          failed_d   = 1'b0;
        end
        tgarle_pkg::EVT_END: begin
          if (!(finished_q || failed_q)) begin
            failed_d           = 1'b1;
            out_valid_d        = 1'b1;
            out_d.pixel_color  = '0;
            out_d.repeat_count = '0;
            out_d.end_of_image = 1'b0;
            out_d.status       = tgarle_pkg::STAT_EARLY_END;
          end
        end
        tgarle_pkg::EVT_PIXEL: begin
          if (!(finished_q || failed_q)) begin
            out_valid_d = 1'b1;
            if (over) begin
              done_d             = total_i;
              failed_d           = 1'b1;
              out_d.pixel_color  = (rep_clip != '0) ? evt_i.color : '0;
              out_d.repeat_count = rep_clip;
              out_d.end_of_image = 1'b0;
              out_d.status       = tgarle_pkg::STAT_TOO_MANY;
            end else begin
              done_d             = done_sum;
              finished_d         = evt_i.last && (done_sum >= total_i);
              out_d.pixel_color  = evt_i.color;
              out_d.repeat_count = evt_i.rep;
              out_d.end_of_image = evt_i.last && (done_sum >= total_i);
              out_d.status       = tgarle_pkg::STAT_OK;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      finished_q  <= 1'b0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      finished_q  <= finished_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[design/tga_rle_pixel_decoder.sv]
// TGA run-length pixel decoder, top level: config registers, front end,
// event queue, back end. Depends on tgarle_pkg and the tgarle_* modules.
// Throughput: one input transfer per cycle while the queue has room; a
// result passes queue and output register after its pixel's last byte. The
// two-entry queue and output register decouple input and output stalls.
// Reset: decoding state cleared, bytes_per_pixel = 3, pixel_total = 1.
module tga_rle_pixel_decoder #(
  parameter int unsigned PixelCountBits = tgarle_pkg::PixelCountBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  tgarle_pkg::cfg_index_e               cfg_index_i,
  input  logic [tgarle_pkg::CfgDataBits-1:0]   cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  tgarle_pkg::in_item_t                 in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output tgarle_pkg::out_item_t                out_item_o
);

  logic [tgarle_pkg::BppBits-1:0] bpp_q;
  logic [PixelCountBits-1:0]      total_q;
  logic                           push;
  tgarle_pkg::evt_t               push_evt;
  logic                           push_ready;
  logic                           pop_valid;
  tgarle_pkg::evt_t               pop_evt;
  logic                           pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= tgarle_pkg::BppReset;
      total_q <= tgarle_pkg::PixelTotalReset[PixelCountBits-1:0];
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tgarle_pkg::CFG_BYTES_PER_PIXEL: bpp_q <= cfg_data_i[tgarle_pkg::BppBits-1:0];
        tgarle_pkg::CFG_PIXEL_TOTAL:     total_q <= cfg_data_i[PixelCountBits-1:0];
        default: begin
        end
      endcase
    end
  end

  tgarle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .bpp_i        (bpp_q),
    .push_o       (push),
    .evt_o        (push_evt),
    .push_ready_i (push_ready)
  );

  tgarle_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_evt_i   (push_evt),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_evt_o    (pop_evt),
    .pop_i        (pop)
  );

  tgarle_back #(
    .PixelCountBits (PixelCountBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (pop_valid),
    .evt_i       (pop_evt),
    .evt_pop_o   (pop),
    .total_i     (total_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
